@@ hdl/v3a_pkg.sv @@
// ----------------------------------------------------------------------------
// v3a_pkg
// Types, codes and constants shared by the 3D vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_SCALE  = 3'd2,
    OP_DOT    = 3'd3,
    OP_CROSS  = 3'd4,
    OP_LENGTH = 3'd5,
    OP_NORM   = 3'd6,
    OP_ROTATE = 3'd7
  } op_t;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // fixed-point constants, Q2.30
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic [33:0]        GAIN_Q30    = 34'd652032874;

  // arctangent table, Q2.30
  localparam int ATAN_LEN = 30;
  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
    32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
    32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
    32'd31, 32'd15, 32'd8, 32'd4, 32'd2
  };

  // three 32-bit coordinates, index 0 is x
  typedef logic [2:0][31:0] vec_t;

  // merging stage results
  typedef struct packed {
    vec_t        r;
    logic [31:0] sc;
    logic        sat;
    logic [63:0] ss;
  } merge_t;

  // context carried by every item through the long pipeline
  typedef struct packed {
    op_t              op;
    logic [2:0]       rot;
    vec_t             a;
    vec_t             r;
    logic [31:0]      sc;
    logic             sat;
    logic             zero;
    logic [63:0]      sq_rem;
    logic [63:0]      sq_root;
    logic [33:0]      cx;
    logic [33:0]      cy;
    logic [34:0]      cz;
    logic             flip;
    logic [2:0][48:0] dv_rem;
    logic [2:0][16:0] dv_q;
    logic [2:0]       neg;
    logic [3:0][63:0] tm;
  } ctx_t;

  // clip to signed 32 bits, flag in the top bit
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] res;
    if (v > 66'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

@@ hdl/v3a_lane.sv @@
// ----------------------------------------------------------------------------
// v3a_lane
// One coordinate lane: two operand-selected multipliers and an adder.
// ----------------------------------------------------------------------------
module v3a_lane #(
  parameter int LANE = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  v3a_pkg::op_t          op,
  input  v3a_pkg::vec_t         a,
  input  v3a_pkg::vec_t         b,
  input  logic [31:0]           f,
  output logic signed [63:0]    prod1,
  output logic signed [63:0]    prod2,
  output logic signed [32:0]    addsub
);
  import v3a_pkg::*;

  localparam int J = (LANE + 1) % 3;
  localparam int K = (LANE + 2) % 3;

  logic signed [31:0] m1a, m1b, m2a, m2b;
  logic signed [63:0] prod1_r, prod2_r;
  logic signed [32:0] addsub_r;
  logic signed [32:0] addsub_nxt;

  // operand selection per operation
  always_comb begin
    m1a = $signed(a[LANE]);
    m1b = $signed(b[LANE]);
    case (op)
      OP_SCALE: m1b = $signed(f);
      OP_DOT:   m1b = $signed(b[LANE]);
      OP_LENGTH,
      OP_NORM:  m1b = $signed(a[LANE]);
      OP_CROSS: begin
        m1a = $signed(a[J]);
        m1b = $signed(b[K]);
      end
      default:  m1b = $signed(b[LANE]);
    endcase
    m2a = $signed(a[K]);
    m2b = $signed(b[J]);
    if (op == OP_SUB) begin
      addsub_nxt = 33'($signed(a[LANE])) - 33'($signed(b[LANE]));
    end else begin
      addsub_nxt = 33'($signed(a[LANE])) + 33'($signed(b[LANE]));
    end
  end

  // product registers
  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r  <= m1a * m1b;
      prod2_r  <= m2a * m2b;
      addsub_r <= addsub_nxt;
    end
  end

  assign prod1  = prod1_r;
  assign prod2  = prod2_r;
  assign addsub = addsub_r;

endmodule

@@ hdl/v3a_merge.sv @@
// ----------------------------------------------------------------------------
// v3a_merge
// Combines the lane products into sums, differences and saturated results.
// ----------------------------------------------------------------------------
module v3a_merge (
  input  v3a_pkg::op_t          op,
  input  logic [2:0][63:0]      prod1,
  input  logic [2:0][63:0]      prod2,
  input  logic [2:0][32:0]      addsub,
  output v3a_pkg::merge_t       res
);
  import v3a_pkg::*;

  logic signed [65:0] dsum;
  logic signed [65:0] lane_v [3];
  logic [32:0]        s;

  always_comb begin
    res  = '0;
    dsum = 66'($signed(prod1[0])) + 66'($signed(prod1[1])) + 66'($signed(prod1[2]));
    res.ss = dsum[63:0];
    s = '0;
    // per-lane value before clipping
    for (int i = 0; i < 3; i++) begin
      case (op)
        OP_ADD,
        OP_SUB:   lane_v[i] = 66'($signed(addsub[i]));
        OP_SCALE: lane_v[i] = 66'($signed(prod1[i])) >>> 16;
        OP_CROSS: lane_v[i] = (66'($signed(prod1[i])) - 66'($signed(prod2[i]))) >>> 16;
        default:  lane_v[i] = '0;
      endcase
    end
    case (op)
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          s = sat32(lane_v[i]);
          res.r[i] = s[31:0];
          res.sat  = res.sat | s[32];
        end
      end
      OP_DOT: begin
        s = sat32(dsum >>> 16);
        res.sc  = s[31:0];
        res.sat = s[32];
      end
      default: res.sat = 1'b0;
    endcase
  end

endmodule

@@ hdl/vector3_alu.sv @@
// ----------------------------------------------------------------------------
// vector3_alu
// Every op takes the same path through all stages, from input item to result item.
// Throughput: one item per cycle while out_stall is low; the 32-stage square root and
// the 17-stage divider are both fully pipelined. Bubbles collapse under stall.
// Reset: synchronous rst_n clears the stage valid bits; no other state.
// ----------------------------------------------------------------------------
module vector3_alu #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_a_x,
  input  logic [31:0] in_a_y,
  input  logic [31:0] in_a_z,
  input  logic [31:0] in_b_x,
  input  logic [31:0] in_b_y,
  input  logic [31:0] in_b_z,
  input  logic [31:0] in_scale_factor,
  input  logic [18:0] in_angle,
  input  logic        in_rot_x,
  input  logic        in_rot_y,
  input  logic        in_rot_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_r_x,
  output logic [31:0] out_r_y,
  output logic [31:0] out_r_z,
  output logic [31:0] out_r_scalar,
  output logic [1:0]  out_status
);
  import v3a_pkg::*;

  localparam int NSTEP  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int NSQ    = 32;
  localparam int NDIV   = 17;
  localparam int S_SQ   = 2;
  localparam int S_POST = S_SQ + NSQ;
  localparam int S_DIV  = S_POST + 1;
  localparam int S_FIN  = S_DIV + NDIV;
  localparam int NST    = S_FIN + 1;

  ctx_t             st_r [NST];
  logic [NST-1:0]   v_r;
  logic [NST:0]     rdy;
  logic [NST-1:0]   v_in;
  vec_t             in_a, in_b;
  logic [2:0][63:0] prod1, prod2;
  logic [2:0][32:0] addsub;
  merge_t           mrg;
  ctx_t             s0_nxt;
  ctx_t             s1_nxt;

  assign in_a = {in_a_z, in_a_y, in_a_x};
  assign in_b = {in_b_z, in_b_y, in_b_x};

  // stage handshake: a stage loads when empty or when its successor loads
  assign rdy[NST] = !out_stall;
  generate
    for (genvar k = 0; k < NST; k++) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end
  endgenerate
  assign in_stall = !rdy[0];
  assign v_in     = {v_r[NST-2:0], in_valid};

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_in[k];
      end
    end
  end

  // lanes
  generate
    for (genvar i = 0; i < 3; i++) begin : g_lane
      v3a_lane #(.LANE(i)) u_lane (
        .clk    (clk),
        .en     (rdy[0]),
        .op     (op_t'(in_req_type)),
        .a      (in_a),
        .b      (in_b),
        .f      (in_scale_factor),
        .prod1  (prod1[i]),
        .prod2  (prod2[i]),
        .addsub (addsub[i])
      );
    end
  endgenerate

  // merging stage logic
  v3a_merge u_merge (
    .op     (st_r[0].op),
    .prod1  (prod1),
    .prod2  (prod2),
    .addsub (addsub),
    .res    (mrg)
  );

  // stage 0: capture item, fold the angle into plus or minus pi/2
  always_comb begin : b_s0
    ctx_t             ctx_nxt;
    logic signed [34:0] z0;
    ctx_nxt     = '0;
    ctx_nxt.op  = op_t'(in_req_type);
    ctx_nxt.rot = {in_rot_z, in_rot_y, in_rot_x};
    ctx_nxt.a   = in_a;
    z0 = {{2{in_angle[18]}}, in_angle, 14'd0};
    if (z0 > HALF_PI_Q30) begin
      ctx_nxt.cz   = z0 - PI_Q30;
      ctx_nxt.flip = 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      ctx_nxt.cz   = z0 + PI_Q30;
      ctx_nxt.flip = 1'b1;
    end else begin
      ctx_nxt.cz   = z0;
      ctx_nxt.flip = 1'b0;
    end
    s0_nxt = ctx_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) st_r[0] <= s0_nxt;
  end

  // stage 1: merged results, seed square root and cordic
  always_comb begin
    s1_nxt         = st_r[0];
    s1_nxt.r       = mrg.r;
    s1_nxt.sc      = mrg.sc;
    s1_nxt.sat     = mrg.sat;
    s1_nxt.sq_rem  = mrg.ss;
    s1_nxt.sq_root = '0;
    s1_nxt.cx      = GAIN_Q30;
    s1_nxt.cy      = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) st_r[1] <= s1_nxt;
  end

  // square root, one result bit a stage, alongside cordic micro-rotations
  generate
    for (genvar j = 0; j < NSQ; j++) begin : g_sq
      localparam int K = S_SQ + j;
      localparam int AIDX = (j < ATAN_LEN) ? j : 0;
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
      ctx_t ctx_nxt;
      always_comb begin
        logic [63:0]        trial;
        logic signed [33:0] xs, ys, dx, dy;
        ctx_nxt = st_r[K-1];
        trial   = st_r[K-1].sq_root + SQ_BIT;
        if (st_r[K-1].sq_rem >= trial) begin
          ctx_nxt.sq_rem  = st_r[K-1].sq_rem - trial;
          ctx_nxt.sq_root = (st_r[K-1].sq_root >> 1) + SQ_BIT;
        end else begin
          ctx_nxt.sq_root = st_r[K-1].sq_root >> 1;
        end
        xs = $signed(st_r[K-1].cx);
        ys = $signed(st_r[K-1].cy);
        dx = ys >>> j;
        dy = xs >>> j;
        if (j < NSTEP) begin
          if (!st_r[K-1].cz[34]) begin
            ctx_nxt.cx = xs - dx;
            ctx_nxt.cy = ys + dy;
            ctx_nxt.cz = st_r[K-1].cz - {3'd0, ATAN_Q30[AIDX]};
          end else begin
            ctx_nxt.cx = xs + dx;
            ctx_nxt.cy = ys - dy;
            ctx_nxt.cz = st_r[K-1].cz + {3'd0, ATAN_Q30[AIDX]};
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[K]) st_r[K] <= ctx_nxt;
      end
    end
  endgenerate

  // post stage: length result, divider seed, sin and cos sign
  ctx_t post_nxt;
  always_comb begin
    logic [31:0] len;
    logic [31:0] mag;
    post_nxt = st_r[S_POST-1];
    len      = st_r[S_POST-1].sq_root[31:0];
    case (st_r[S_POST-1].op)
      OP_LENGTH: begin
        if (len[31]) begin
          post_nxt.sc  = 32'h7FFF_FFFF;
          post_nxt.sat = 1'b1;
        end else begin
          post_nxt.sc = len;
        end
      end
      OP_NORM:   post_nxt.zero = (len == 32'd0);
      OP_ROTATE: post_nxt.r    = st_r[S_POST-1].a;
      default:   post_nxt.zero = 1'b0;
    endcase
    if (st_r[S_POST-1].flip) begin
      post_nxt.cx = 34'd0 - st_r[S_POST-1].cx;
      post_nxt.cy = 34'd0 - st_r[S_POST-1].cy;
    end
    for (int i = 0; i < 3; i++) begin
      post_nxt.neg[i] = st_r[S_POST-1].a[i][31];
      mag = st_r[S_POST-1].a[i][31] ? (32'd0 - st_r[S_POST-1].a[i])
                                    : st_r[S_POST-1].a[i];
      post_nxt.dv_rem[i] = {1'b0, mag, 16'd0};
      post_nxt.dv_q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_POST]) st_r[S_POST] <= post_nxt;
  end

  // divider, one quotient bit a stage; the axis turns run in the first six
  generate
    for (genvar d = 0; d < NDIV; d++) begin : g_div
      localparam int K  = S_DIV + d;
      localparam int BP = NDIV - 1 - d;
      localparam int T  = d / 2;
      localparam int P  = (T == 0) ? 1 : ((T == 1) ? 2 : 0);
      localparam int Q  = (T == 0) ? 2 : ((T == 1) ? 0 : 1);
      ctx_t ctx_nxt;
      always_comb begin
        logic [48:0]        dv;
        logic               act;
        logic signed [31:0] cc, sn, rp, rq;
        logic signed [63:0] t0, t1, t2, t3;
        logic signed [64:0] dp, dq;
        logic [32:0]        sp, sq;
        ctx_nxt = st_r[K-1];
        dv = {17'd0, st_r[K-1].sq_root[31:0]} << BP;
        for (int i = 0; i < 3; i++) begin
          if (st_r[K-1].dv_rem[i] >= dv) begin
            ctx_nxt.dv_rem[i]   = st_r[K-1].dv_rem[i] - dv;
            ctx_nxt.dv_q[i][BP] = 1'b1;
          end
        end
        act = (st_r[K-1].op == OP_ROTATE) && st_r[K-1].rot[T % 3];
        cc  = $signed(st_r[K-1].cx[31:0]);
        sn  = $signed(st_r[K-1].cy[31:0]);
        rp  = $signed(st_r[K-1].r[P]);
        rq  = $signed(st_r[K-1].r[Q]);
        t0  = $signed(st_r[K-1].tm[0]);
        t1  = $signed(st_r[K-1].tm[1]);
        t2  = $signed(st_r[K-1].tm[2]);
        t3  = $signed(st_r[K-1].tm[3]);
        dp  = 65'(t0) - 65'(t1);
        dq  = 65'(t2) + 65'(t3);
        sp  = sat32(66'(dp >>> 30));
        sq  = sat32(66'(dq >>> 30));
        if (d < 6) begin
          if ((d % 2) == 0) begin
            // products of the turn
            ctx_nxt.tm[0] = cc * rp;
            ctx_nxt.tm[1] = sn * rq;
            ctx_nxt.tm[2] = sn * rp;
            ctx_nxt.tm[3] = cc * rq;
          end else if (act) begin
            // sums, scaling and clipping of the turn
            ctx_nxt.r[P] = sp[31:0];
            ctx_nxt.r[Q] = sq[31:0];
            ctx_nxt.sat  = st_r[K-1].sat | sp[32] | sq[32];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[K]) st_r[K] <= ctx_nxt;
      end
    end
  endgenerate

  // final stage: signed normalized components, output register
  ctx_t fin_nxt;
  always_comb begin
    logic [31:0] qe;
    fin_nxt = st_r[S_FIN-1];
    for (int i = 0; i < 3; i++) begin
      qe = {15'd0, st_r[S_FIN-1].dv_q[i]};
      if (st_r[S_FIN-1].op == OP_NORM && !st_r[S_FIN-1].zero) begin
        fin_nxt.r[i] = st_r[S_FIN-1].neg[i] ? (32'd0 - qe) : qe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_FIN]) st_r[S_FIN] <= fin_nxt;
  end

  // result ports
  assign out_valid    = v_r[NST-1];
  assign out_r_x      = st_r[S_FIN].r[0];
  assign out_r_y      = st_r[S_FIN].r[1];
  assign out_r_z      = st_r[S_FIN].r[2];
  assign out_r_scalar = st_r[S_FIN].sc;
  assign out_status   = st_r[S_FIN].zero ? ST_ZERO : (st_r[S_FIN].sat ? ST_SAT : ST_OK);

  // checks
  a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_SAT || out_status == ST_ZERO))
    else $error("undefined status code");

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ZERO) |->
      (out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_scalar == '0))
    else $error("zero-length result carries data");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled while the pipeline has a bubble");

  a_length_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[S_FIN] && (st_r[S_FIN].op == OP_LENGTH || st_r[S_FIN].op == OP_DOT)) |->
      (st_r[S_FIN].r == '0))
    else $error("scalar op left vector data");

endmodule
